FILE: hw/rtl/sssr_pkg.sv
`default_nettype none
package sssr_pkg;

  localparam int CW = 15;
  localparam int PW = 20;
  localparam int DW = 15;
  localparam int CNTW = 4;

  localparam logic [7:0] BLANK = 8'd32;
  localparam logic [7:0] MIN_ROWS = 8'd5;

  localparam logic [1:0] REG_GRID_H = 2'd0;
  localparam logic [1:0] REG_GRID_W = 2'd1;
  localparam logic [1:0] REG_SEG_FILL = 2'd2;
  localparam logic [1:0] REG_SPE_FILL = 2'd3;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  localparam logic [7:0] LIT_TOP = 8'h40;
  localparam logic [7:0] LIT_UL = 8'h20;
  localparam logic [7:0] LIT_UR = 8'h10;
  localparam logic [7:0] LIT_MID = 8'h08;
  localparam logic [7:0] LIT_LL = 8'h04;
  localparam logic [7:0] LIT_LR = 8'h02;
  localparam logic [7:0] LIT_BOT = 8'h01;
  localparam logic [7:0] LIT_L = LIT_UL | LIT_LL;
  localparam logic [7:0] LIT_R = LIT_UR | LIT_LR;
  localparam logic [7:0] LIT_V = LIT_L | LIT_R;
  localparam logic [7:0] LIT_H = LIT_TOP | LIT_MID | LIT_BOT;
  localparam logic [7:0] KNOWN = 8'h80;

  typedef enum logic [3:0] {
    S_IDLE,
    S_L_START,
    S_L_DIV1,
    S_L_TAKE,
    S_L_GAP,
    S_L_DIV2,
    S_L_FIN,
    S_L_USED,
    S_Q_START,
    S_WALK_RD,
    S_WALK_EV,
    S_Q_DONE
  } state_e;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] num;
    logic [DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] quot;
  } div_rsp_t;

  function automatic logic is_special(input logic [7:0] c);
    return (c == CH_COLON) || (c == CH_PERIOD) || (c == CH_SEMI);
  endfunction

  function automatic logic [7:0] glyph_mask(input logic [7:0] c);
    logic [7:0] m;
    m = 8'h00;
    unique case (c)
      "0": m = KNOWN | LIT_TOP | LIT_BOT | LIT_V;
      "1": m = KNOWN | LIT_R;
      "2": m = KNOWN | LIT_H | LIT_UR | LIT_LL;
      "3": m = KNOWN | LIT_H | LIT_R;
      "4": m = KNOWN | LIT_R | LIT_UL | LIT_MID;
      "5": m = KNOWN | LIT_H | LIT_UL | LIT_LR;
      "6": m = KNOWN | LIT_H | LIT_L | LIT_LR;
      "7": m = KNOWN | LIT_R | LIT_TOP;
      "8": m = KNOWN | LIT_H | LIT_V;
      "9": m = KNOWN | LIT_R | LIT_H | LIT_UL;
      "A": m = KNOWN | LIT_MID | LIT_V | LIT_TOP;
      "a": m = KNOWN | LIT_H | LIT_R | LIT_LL;
      "B", "b": m = KNOWN | LIT_MID | LIT_BOT | LIT_LR | LIT_L;
      "C": m = KNOWN | LIT_BOT | LIT_TOP | LIT_L;
      "c": m = KNOWN | LIT_BOT | LIT_MID | LIT_LL;
      "D", "d": m = KNOWN | LIT_MID | LIT_BOT | LIT_LL | LIT_R;
      "E": m = KNOWN | LIT_H | LIT_L;
      "e": m = KNOWN | LIT_H | LIT_L | LIT_UR;
      "F", "f": m = KNOWN | LIT_MID | LIT_TOP | LIT_L;
      "G", "g": m = KNOWN | LIT_BOT | LIT_TOP | LIT_L | LIT_LR;
      "H", "K", "X", "x": m = KNOWN | LIT_R | LIT_L | LIT_MID;
      "h", "k": m = KNOWN | LIT_MID | LIT_L | LIT_LR;
      "I": m = KNOWN | LIT_L;
      "i": m = KNOWN | LIT_LL;
      "J": m = KNOWN | LIT_BOT | LIT_R;
      "j": m = KNOWN | LIT_BOT | LIT_LR | LIT_TOP;
      "L", "l": m = KNOWN | LIT_BOT | LIT_L;
      "M", "N": m = KNOWN | LIT_R | LIT_L | LIT_TOP;
      "m", "n": m = KNOWN | LIT_MID | LIT_LL | LIT_LR;
      "O", "o": m = KNOWN | LIT_MID | LIT_LL | LIT_LR | LIT_BOT;
      "P", "p": m = KNOWN | LIT_MID | LIT_TOP | LIT_UR | LIT_L;
      "Q", "q": m = KNOWN | LIT_MID | LIT_TOP | LIT_UL | LIT_R;
      "R", "r": m = KNOWN | LIT_MID | LIT_LL;
      "S", "s": m = KNOWN | LIT_H | LIT_UL | LIT_LR;
      "T", "t": m = KNOWN | LIT_MID | LIT_L | LIT_BOT;
      "U", "V", "W": m = KNOWN | LIT_R | LIT_L | LIT_BOT;
      "u", "v", "w": m = KNOWN | LIT_BOT | LIT_LR | LIT_LL;
      "Y", "y": m = KNOWN | LIT_MID | LIT_BOT | LIT_R | LIT_UL;
      "Z", "z": m = KNOWN | LIT_H | LIT_UR | LIT_LL;
      "_": m = KNOWN | LIT_BOT;
      "-": m = KNOWN | LIT_MID;
      " ": m = KNOWN;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] div10(input logic [7:0] x);
    logic [18:0] p;
    p = 19'(x) * 19'd205;
    return 8'(p >> 11);
  endfunction

  function automatic logic [12:0] div6(input logic [12:0] x);
    logic [25:0] p;
    p = 26'(x) * 26'd2731;
    return 13'(p >> 14);
  endfunction

  function automatic logic [9:0] div5(input logic [9:0] x);
    logic [17:0] p;
    p = 18'(x) * 18'd205;
    return 10'(p >> 10);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/scaled_seven_segment_text_renderer_unit.sv
// Append: no result. Query: a start step, then one message memory read and one
// evaluation per message position walked, then a done step; the first query after
// any register write or append first rebuilds the layout through the serial
// divider (up to two divisions).
// One item is in flight at a time; a result waits in the output register.
// Async reset: config and control registers take defaults, the message is empty.
`default_nettype none
module scaled_seven_segment_text_renderer_unit #(
  parameter int MAX_MSG_LEN = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        first_char_i,
  input  wire logic [7:0]  row_i,
  input  wire logic [11:0] col_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       cell_char_o,
  output logic             no_space_o,
  output logic [11:0]      used_width_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [11:0] cfg_data_i
);
  import sssr_pkg::*;

  localparam int LW = $clog2(MAX_MSG_LEN + 1);
  localparam int AW = (MAX_MSG_LEN > 1) ? $clog2(MAX_MSG_LEN) : 1;

  state_e state_q, state_d;

  logic [7:0]  h_q, w_seg_q, spf_q;
  logic [11:0] w_q;
  logic        lv_q, lv_d;
  logic [LW-1:0] len_q, len_d, g_q, g_d, s_q, s_d, idx_q, idx_d;

  logic [12:0] gw_q, gw_d, dot_q, dot_d, gap_q, gap_d, shift_q, shift_d;
  logic [PW-1:0] taken_q, taken_d, used_q, used_d, pos_q, pos_d;
  logic [7:0]  thick_q, thick_d, mhi_q, mhi_d, r1_q, r1_d, r2_q, r2_d;
  logic [6:0]  mid_q, mid_d;
  logic signed [9:0] mlo_q, mlo_d;

  logic [7:0]  res_cell_q, res_cell_d;
  logic        res_ns_q, res_ns_d;
  logic [7:0]  row_q, row_d;
  logic [11:0] col_q, col_d;

  logic        ov_q, ov_d;
  logic [7:0]  oc_q, oc_d;
  logic        ons_q, ons_d;
  logic [11:0] ou_q, ou_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_rdata;

  logic [LW:0]   n_w;
  logic [CW-1:0] gaps_w, min_cols_w;
  logic          fits_w, in_acc;

  logic [LW-1:0] base_len, base_g, base_s;
  logic          ch_sp, ch_known;

  logic          ev_sp, lit;
  logic [7:0]    ev_mask;
  logic [PW-1:0] ev_w, ev_x;
  logic [7:0]    ev_y;
  logic [9:0]    r1_raw, r2_raw;
  logic [7:0]    r1_adj;

  sssr_msg_mem #(.DEPTH(MAX_MSG_LEN), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (char_code_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sssr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign n_w        = (LW + 1)'(g_q) + (LW + 1)'(s_q);
  assign gaps_w     = (n_w != '0) ? CW'(n_w) - CW'(1) : '0;
  assign min_cols_w = CW'(3) * CW'(g_q) + CW'(s_q) + gaps_w;
  assign fits_w     = (h_q >= MIN_ROWS) && (CW'(w_q) >= min_cols_w);
  assign in_acc     = in_valid_i && in_ready_o;

  assign base_len = first_char_i ? '0 : len_q;
  assign base_g   = first_char_i ? '0 : g_q;
  assign base_s   = first_char_i ? '0 : s_q;
  assign ch_sp    = is_special(char_code_i);
  assign ch_known = (glyph_mask(char_code_i) & KNOWN) != '0;

  // Cell evaluation for the entry read from memory
  always_comb begin
    ev_sp   = is_special(mem_rdata);
    ev_mask = glyph_mask(mem_rdata);
    ev_w    = ev_sp ? PW'(dot_q) : PW'(gw_q);
    ev_x    = PW'(col_q) - pos_q;
    ev_y    = row_q;
    lit     = 1'b0;
    if ((ev_mask & LIT_TOP) != '0 && ev_y <= thick_q) lit = 1'b1;
    if ((ev_mask & LIT_MID) != '0 && $signed({2'b00, ev_y}) >= mlo_q && ev_y <= mhi_q) begin
      lit = 1'b1;
    end
    if ((ev_mask & LIT_BOT) != '0 && (9'(ev_y) + 9'(thick_q)) >= (9'(h_q) - 9'd1)) begin
      lit = 1'b1;
    end
    if (ev_x <= PW'(thick_q)) begin
      if ((ev_mask & LIT_UL) != '0 && ev_y <= 8'(mid_q)) lit = 1'b1;
      if ((ev_mask & LIT_LL) != '0 && ev_y >= 8'(mid_q)) lit = 1'b1;
    end
    if (ev_x + PW'(thick_q) + PW'(1) >= PW'(gw_q)) begin
      if ((ev_mask & LIT_UR) != '0 && ev_y <= 8'(mid_q)) lit = 1'b1;
      if ((ev_mask & LIT_LR) != '0 && ev_y >= 8'(mid_q)) lit = 1'b1;
    end
  end

  assign r1_raw = div5(10'(({2'b00, h_q} - 10'd1) << 1));
  assign r2_raw = div5(10'(({2'b00, h_q} - 10'd1) << 2));
  assign r1_adj = (8'(r1_raw) >= (h_q >> 1)) ? 8'(r1_raw) - 8'd1 : 8'(r1_raw);

  // Next state and datapath
  always_comb begin
    state_d    = state_q;
    lv_d       = lv_q;
    len_d      = len_q;
    g_d        = g_q;
    s_d        = s_q;
    idx_d      = idx_q;
    gw_d       = gw_q;
    dot_d      = dot_q;
    gap_d      = gap_q;
    shift_d    = shift_q;
    taken_d    = taken_q;
    used_d     = used_q;
    pos_d      = pos_q;
    thick_d    = thick_q;
    mhi_d      = mhi_q;
    mlo_d      = mlo_q;
    mid_d      = mid_q;
    r1_d       = r1_q;
    r2_d       = r2_q;
    res_cell_d = res_cell_q;
    res_ns_d   = res_ns_q;
    row_d      = row_q;
    col_d      = col_q;
    ov_d       = ov_q && !out_ready_i;
    oc_d       = oc_q;
    ons_d      = ons_q;
    ou_d       = ou_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!kind_i) begin
            len_d = base_len;
            g_d   = base_g;
            s_d   = base_s;
            lv_d  = 1'b0;
            if (base_len < LW'(MAX_MSG_LEN)) begin
              if (ch_sp) begin
                len_d = base_len + LW'(1);
                s_d   = base_s + LW'(1);
              end else if (ch_known) begin
                len_d = base_len + LW'(1);
                g_d   = base_g + LW'(1);
              end
            end
          end else begin
            row_d   = row_i;
            col_d   = col_i;
            state_d = lv_q ? S_Q_START : S_L_START;
          end
        end
      end
      S_L_START: begin
        gw_d  = '0;
        dot_d = 13'd1;
        gap_d = 13'd1;
        if (n_w != '0 && CW'(w_q) >= min_cols_w) begin
          state_d = S_L_DIV1;
        end else begin
          state_d = S_L_FIN;
        end
      end
      S_L_DIV1: begin
        if (div_rsp.done) begin
          gw_d  = 13'(div_rsp.quot);
          dot_d = (div_rsp.quot[DW-1:1] == '0) ? 13'd1 : 13'(div_rsp.quot >> 1);
          state_d = (gaps_w != '0) ? S_L_TAKE : S_L_FIN;
        end
      end
      S_L_TAKE: begin
        taken_d = PW'(g_q) * PW'(gw_q) + PW'(s_q) * PW'(dot_q);
        state_d = S_L_GAP;
      end
      S_L_GAP: begin
        state_d = (taken_q < PW'(w_q)) ? S_L_DIV2 : S_L_FIN;
      end
      S_L_DIV2: begin
        if (div_rsp.done) begin
          gap_d   = (div_rsp.quot == '0) ? 13'd1 : 13'(div_rsp.quot);
          state_d = S_L_FIN;
        end
      end
      S_L_FIN: begin
        taken_d = PW'(g_q) * PW'(gw_q) + PW'(s_q) * PW'(dot_q);
        thick_d = (13'(div10(h_q)) < div6(gw_q)) ? div10(h_q) : 8'(div6(gw_q));
        mid_d   = 7'((h_q - 8'd1) >> 1);
        r1_d    = r1_adj;
        r2_d    = (8'(r2_raw) < r1_adj + 8'd2) ? 8'(r2_raw) + 8'd1 : 8'(r2_raw);
        shift_d = (dot_q > 13'd1) ? (dot_q >> 1) - 13'd1 : '0;
        state_d = S_L_USED;
      end
      S_L_USED: begin
        used_d  = taken_q + PW'(gaps_w) * PW'(gap_q);
        mlo_d   = $signed({3'b000, mid_q}) - $signed({2'b00, thick_q})
                  + $signed({3'b000, thick_q[7:1]});
        mhi_d   = 8'(mid_q) + (thick_q >> 1);
        lv_d    = 1'b1;
        state_d = S_Q_START;
      end
      S_Q_START: begin
        res_cell_d = BLANK;
        res_ns_d   = !fits_w;
        idx_d      = '0;
        pos_d      = '0;
        if (fits_w && row_q < h_q && PW'(col_q) < used_q) begin
          state_d = S_WALK_RD;
        end else begin
          state_d = S_Q_DONE;
        end
      end
      S_WALK_RD: begin
        state_d = (idx_q < len_q) ? S_WALK_EV : S_Q_DONE;
      end
      S_WALK_EV: begin
        if (PW'(col_q) < pos_q + ev_w) begin
          if (ev_sp) begin
            if (PW'(col_q) - pos_q == PW'(shift_q)) begin
              if (mem_rdata == CH_COLON && (row_q == r1_q || row_q == r2_q)) begin
                res_cell_d = spf_q;
              end
              if (mem_rdata == CH_PERIOD && row_q == h_q - 8'd1) begin
                res_cell_d = spf_q;
              end
            end
          end else if (lit) begin
            res_cell_d = w_seg_q;
          end
          state_d = S_Q_DONE;
        end else if (PW'(col_q) < pos_q + ev_w + PW'(gap_q)) begin
          state_d = S_Q_DONE;
        end else begin
          pos_d   = pos_q + ev_w + PW'(gap_q);
          idx_d   = idx_q + LW'(1);
          state_d = S_WALK_RD;
        end
      end
      S_Q_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          oc_d    = res_cell_q;
          ons_d   = res_ns_q;
          ou_d    = res_ns_q ? '0 : used_q[11:0];
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cfg_we_i) begin
      lv_d = 1'b0;
    end
  end

  // Outputs
  always_comb begin
    in_ready_o   = (state_q == S_IDLE);
    mem_we       = in_acc && !kind_i && base_len < LW'(MAX_MSG_LEN) && (ch_sp || ch_known);
    mem_waddr    = base_len[AW-1:0];
    mem_re       = (state_q == S_WALK_RD);
    mem_raddr    = idx_q[AW-1:0];
    div_req      = '0;
    if (state_q == S_L_START) begin
      div_req.start = (n_w != '0) && (CW'(w_q) >= min_cols_w);
      div_req.num   = DW'((CW'(w_q) - gaps_w) << 1);
      div_req.den   = DW'(s_q) + DW'(DW'(g_q) << 1);
    end else if (state_q == S_L_GAP) begin
      div_req.start = (taken_q < PW'(w_q));
      div_req.num   = DW'(PW'(w_q) - taken_q);
      div_req.den   = DW'(gaps_w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      h_q     <= 8'd5;
      w_q     <= 12'd64;
      w_seg_q <= 8'd35;
      spf_q   <= 8'd46;
      lv_q    <= 1'b0;
      len_q   <= '0;
      g_q     <= '0;
      s_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      lv_q    <= lv_d;
      len_q   <= len_d;
      g_q     <= g_d;
      s_q     <= s_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_GRID_H:   h_q     <= cfg_data_i[7:0];
          REG_GRID_W:   w_q     <= cfg_data_i;
          REG_SEG_FILL: w_seg_q <= cfg_data_i[7:0];
          REG_SPE_FILL: spf_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    gw_q       <= gw_d;
    dot_q      <= dot_d;
    gap_q      <= gap_d;
    shift_q    <= shift_d;
    taken_q    <= taken_d;
    used_q     <= used_d;
    pos_q      <= pos_d;
    thick_q    <= thick_d;
    mhi_q      <= mhi_d;
    mlo_q      <= mlo_d;
    mid_q      <= mid_d;
    r1_q       <= r1_d;
    r2_q       <= r2_d;
    res_cell_q <= res_cell_d;
    res_ns_q   <= res_ns_d;
    row_q      <= row_d;
    col_q      <= col_d;
    oc_q       <= oc_d;
    ons_q      <= ons_d;
    ou_q       <= ou_d;
  end

  assign out_valid_o  = ov_q;
  assign cell_char_o  = oc_q;
  assign no_space_o   = ons_q;
  assign used_width_o = ou_q;

  a_nospace_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_space_o |-> used_width_o == '0 && cell_char_o == BLANK)
    else $error("no-space result carries a cell or width");

  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK_EV |-> $past(state_q) == S_WALK_RD)
    else $error("evaluation without a memory read");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(MAX_MSG_LEN) && (LW + 1)'(g_q) + (LW + 1)'(s_q) == (LW + 1)'(len_q))
    else $error("message counters out of step");

  a_query_layout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_Q_START |-> lv_q)
    else $error("query evaluated on a stale layout");

endmodule
`default_nettype wire

FILE: hw/rtl/sssr_msg_mem.sv
`default_nettype none
module sssr_msg_mem #(
  parameter int DEPTH = 32,
  parameter int AW = 5
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sssr_div.sv
`default_nettype none
module sssr_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sssr_pkg::div_req_t req_i,
  output sssr_pkg::div_rsp_t     rsp_o
);
  import sssr_pkg::*;

  logic [DW:0]     rem_q, rem_d, rem_sh;
  logic [DW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   den_q, den_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q[DW-1:0], quo_q[DW-1]};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = CNTW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule
`default_nettype wire
